// ----- rtl/cbe_pkg.sv -----
// Shared types, constants and sequencing tables for the cubic Bezier easing unit.
// Used by every module in rtl/; depends on nothing else.
package cbe_pkg;

   localparam int FIELD_W = 17;   // width of every request, result and register field
   localparam int QSHIFT  = 30;   // internal fixed point is Q2.30
   localparam int MUL_W   = 33;   // multiplier operand width, holds +/-2.0 in Q2.30
   localparam int ACC_W   = 36;   // sums of products and residuals
   localparam int QUOT_W  = 34;   // saturated Newton quotient
   localparam int IDX_W   = 3;

   localparam logic signed [MUL_W-1:0] ONE_Q = 33'sh0_4000_0000;
   localparam logic signed [65:0] RND_Q = 66'sd536870912;
   localparam logic [ACC_W-1:0] TOL_NEWTON = 36'd10737;
   localparam logic [ACC_W-1:0] TOL_FIT = 36'd1073742;

   localparam logic [FIELD_W-1:0] RST_X1 = 17'd27525;
   localparam logic [FIELD_W-1:0] RST_Y1 = 17'd0;
   localparam logic [FIELD_W-1:0] RST_X2 = 17'd38011;
   localparam logic [FIELD_W-1:0] RST_Y2 = 17'd65536;

   localparam logic [2:0] CURVE_LAST = 3'd6;
   localparam logic [2:0] SLOPE_LAST = 3'd5;

   typedef enum logic [IDX_W-1:0] {
      REG_CURVE_MODE = 3'd0,
      REG_CTRL_X1    = 3'd1,
      REG_CTRL_Y1    = 3'd2,
      REG_CTRL_X2    = 3'd3,
      REG_CTRL_Y2    = 3'd4
   } reg_idx_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_UU, OP_TT, OP_UT, OP_A, OP_B, OP_C,
      OP_AP1, OP_BP2, OP_S1, OP_S2, OP_S3
   } op_type;

   typedef struct packed {
      op_type op;
      logic   sel_y;
      logic   load;
      logic   save_r;
      logic   div_start;
      logic   upd_u;
      logic   bi_init;
      logic   bi_step;
      logic   bi_more;
      logic   out_lin;
      logic   out_bez;
   } cmd_type;

   typedef struct packed {
      logic tiny_r;
      logic tiny_d;
      logic fit_bad;
      logic below;
      logic div_done;
   } sts_type;

   // Curve value: basis terms first, then the two control-point products.
   function automatic op_type curve_op(input logic [2:0] step);
      op_type o;
      unique case (step)
         3'd0: o = OP_UU;
         3'd1: o = OP_TT;
         3'd2: o = OP_A;
         3'd3: o = OP_B;
         3'd4: o = OP_C;
         3'd5: o = OP_AP1;
         3'd6: o = OP_BP2;
         default: o = OP_NONE;
      endcase
      return o;
   endfunction

   // Derivative of the curve.
   function automatic op_type slope_op(input logic [2:0] step);
      op_type o;
      unique case (step)
         3'd0: o = OP_UU;
         3'd1: o = OP_TT;
         3'd2: o = OP_UT;
         3'd3: o = OP_S1;
         3'd4: o = OP_S2;
         3'd5: o = OP_S3;
         default: o = OP_NONE;
      endcase
      return o;
   endfunction

   function automatic logic [ACC_W-1:0] abs_acc(input logic signed [ACC_W-1:0] v);
      return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
   endfunction

endpackage

// ----- rtl/cubic_bezier_easing_unit.sv -----
// Top level of the cubic Bezier easing unit: configuration registers and wiring.
// Depends on cbe_pkg, cbe_ctrl, cbe_datapath and cbe_divider.
// Linear mode passes from S_LOAD straight to S_OUT, where the result strobe is raised;
// Bezier mode runs Newton steps, an optional bisection fallback and the final y evaluation.
// Each Newton step is dominated by the serial divider; every curve
// evaluation takes 7 passes through the single shared multiplier.
// One request at a time; the next is taken the cycle after the strobe.
// Synchronous active-high reset returns to idle and loads the default ease curve.
module cubic_bezier_easing_unit #(
   parameter int FRAC_BITS    = 16,
   parameter int NEWTON_STEPS = 5,
   parameter int BISECT_STEPS = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [cbe_pkg::FIELD_W-1:0]         req_progress,
   output logic                                rsp_valid,
   output logic [cbe_pkg::FIELD_W-1:0]         rsp_eased,
   input  logic                                csr_write_en,
   input  logic [cbe_pkg::IDX_W-1:0]           csr_index,
   input  logic [cbe_pkg::FIELD_W-1:0]         csr_wdata
);

   // Configuration registers. Writes are only expected while the unit is idle,
   // so the datapath reads them directly throughout a computation.
   logic                        mode_ff;
   logic [cbe_pkg::FIELD_W-1:0] x1_ff, y1_ff, x2_ff, y2_ff;

   cbe_pkg::cmd_type cmd;
   cbe_pkg::sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
         x1_ff   <= cbe_pkg::RST_X1;
         y1_ff   <= cbe_pkg::RST_Y1;
         x2_ff   <= cbe_pkg::RST_X2;
         y2_ff   <= cbe_pkg::RST_Y2;
      end else if (csr_write_en) begin
         // Indices past the last register are ignored.
         unique case (csr_index)
            cbe_pkg::REG_CURVE_MODE: mode_ff <= csr_wdata[0];
            cbe_pkg::REG_CTRL_X1:    x1_ff   <= csr_wdata;
            cbe_pkg::REG_CTRL_Y1:    y1_ff   <= csr_wdata;
            cbe_pkg::REG_CTRL_X2:    x2_ff   <= csr_wdata;
            cbe_pkg::REG_CTRL_Y2:    y2_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The controller walks the request through Newton refinement, an optional
   // bisection fallback and the final evaluation of y; the datapath does the sums.
   cbe_ctrl #(
      .NEWTON_STEPS (NEWTON_STEPS),
      .BISECT_STEPS (BISECT_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .mode      (mode_ff),
      .sts       (sts),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   cbe_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .progress (req_progress),
      .x1       (x1_ff),
      .y1       (y1_ff),
      .x2       (x2_ff),
      .y2       (y2_ff),
      .sts      (sts),
      .eased    (rsp_eased)
   );

endmodule

// ----- rtl/cbe_divider.sv -----
// Serial restoring divider for the Newton step, one quotient bit per cycle.
// Depends on cbe_pkg for widths.
module cbe_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [cbe_pkg::ACC_W-1:0]  num,
   input  logic signed [cbe_pkg::ACC_W-1:0]  den,
   output logic                              done,
   output logic signed [cbe_pkg::QUOT_W-1:0] quot
);

   logic [cbe_pkg::ACC_W-1:0] nmag, dmag;
   logic [cbe_pkg::ACC_W-1:0] rem_ff, dsr_ff;
   logic [31:0] low_ff, q_ff;
   logic [5:0] cnt_ff;
   logic run_ff, done_ff, neg_ff, ovf_ff;
   logic [cbe_pkg::ACC_W:0] rem2;
   logic fits;
   logic [32:0] mag;

   assign nmag = cbe_pkg::abs_acc(num);
   assign dmag = cbe_pkg::abs_acc(den);
   assign rem2 = {rem_ff, low_ff[31]};
   assign fits = rem2 >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= 6'd32;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // The quotient only matters up to 2^32: beyond that the clamp on u decides.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {2'b00, nmag[cbe_pkg::ACC_W-1:2]};
         low_ff <= {nmag[1:0], 30'd0};
         dsr_ff <= dmag;
         q_ff   <= '0;
         neg_ff <= num[cbe_pkg::ACC_W-1] ^ den[cbe_pkg::ACC_W-1];
         ovf_ff <= {2'b00, nmag} >= {dmag, 2'b00};
      end else if (run_ff) begin
         rem_ff <= fits ? cbe_pkg::ACC_W'(rem2 - {1'b0, dsr_ff})
                        : cbe_pkg::ACC_W'(rem2);
         low_ff <= {low_ff[30:0], 1'b0};
         q_ff   <= {q_ff[30:0], fits};
      end
   end

   assign mag  = ovf_ff ? 33'h1_0000_0000 : {1'b0, q_ff};
   assign quot = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   assign done = done_ff;

endmodule

// ----- rtl/cbe_datapath.sv -----
// Datapath: shared rounding multiplier, accumulator, Newton and bisection registers.
// Depends on cbe_pkg and instantiates cbe_divider.
module cbe_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cbe_pkg::cmd_type                   cmd,
   input  logic [cbe_pkg::FIELD_W-1:0]        progress,
   input  logic [cbe_pkg::FIELD_W-1:0]        x1,
   input  logic [cbe_pkg::FIELD_W-1:0]        y1,
   input  logic [cbe_pkg::FIELD_W-1:0]        x2,
   input  logic [cbe_pkg::FIELD_W-1:0]        y2,
   output cbe_pkg::sts_type                   sts,
   output logic [cbe_pkg::FIELD_W-1:0]        eased
);

   localparam int SH = cbe_pkg::QSHIFT - FRAC_BITS;
   localparam logic [25:0] ONE_IN = 26'd1 << FRAC_BITS;
   localparam logic [25:0] CTRL_LIM = 26'd2 << FRAC_BITS;
   localparam logic [31:0] HALF = 32'd1 << (SH - 1);
   localparam int MW = cbe_pkg::MUL_W;
   localparam int AW = cbe_pkg::ACC_W;

   function automatic logic signed [MW-1:0] ctrl_q30(input logic [cbe_pkg::FIELD_W-1:0] v);
      logic [25:0] s;
      s = ({9'd0, v} > CTRL_LIM) ? CTRL_LIM : {9'd0, v};
      return $signed(MW'(s) << SH);
   endfunction

   logic [cbe_pkg::FIELD_W-1:0] psat;
   logic signed [MW-1:0] p1, p2, diff, omp2, omt, ma, mb;
   logic signed [65:0] prod, sumr;
   logic signed [AW-1:0] qv, q3, resid, unew;
   logic signed [MW-1:0] x_ff, u_ff, t_ff, lo_ff, hi_ff, uu_ff, tt_ff, a_ff, b_ff;
   logic signed [MW-1:0] lo_new, hi_new, mid_new;
   logic signed [AW-1:0] acc_ff, acc_in, r_ff;
   logic [cbe_pkg::FIELD_W-1:0] psat_ff, eased_ff;
   logic signed [cbe_pkg::QUOT_W-1:0] quot;
   logic div_done;
   logic [30:0] yc;
   logic [31:0] yr;

   assign psat = ({9'd0, progress} > ONE_IN) ? ONE_IN[cbe_pkg::FIELD_W-1:0] : progress;

   assign p1   = cmd.sel_y ? ctrl_q30(y1) : ctrl_q30(x1);
   assign p2   = cmd.sel_y ? ctrl_q30(y2) : ctrl_q30(x2);
   assign diff = p2 - p1;
   assign omp2 = cbe_pkg::ONE_Q - p2;
   assign omt  = cbe_pkg::ONE_Q - t_ff;

   always_comb begin
      ma = t_ff;
      mb = t_ff;
      unique case (cmd.op)
         cbe_pkg::OP_UU:  begin ma = omt;   mb = omt;  end
         cbe_pkg::OP_TT:  begin ma = t_ff;  mb = t_ff; end
         cbe_pkg::OP_UT:  begin ma = omt;   mb = t_ff; end
         cbe_pkg::OP_A:   begin ma = uu_ff; mb = t_ff; end
         cbe_pkg::OP_B:   begin ma = omt;   mb = tt_ff; end
         cbe_pkg::OP_C:   begin ma = tt_ff; mb = t_ff; end
         cbe_pkg::OP_AP1: begin ma = a_ff;  mb = p1;   end
         cbe_pkg::OP_BP2: begin ma = b_ff;  mb = p2;   end
         cbe_pkg::OP_S1:  begin ma = uu_ff; mb = p1;   end
         cbe_pkg::OP_S2:  begin ma = a_ff;  mb = diff; end
         cbe_pkg::OP_S3:  begin ma = tt_ff; mb = omp2; end
         default:         begin ma = t_ff;  mb = t_ff; end
      endcase
   end

   // Product rounded to Q2.30, floor after adding half an LSB.
   assign prod = ma * mb;
   assign sumr = prod + cbe_pkg::RND_Q;
   assign qv   = $signed(sumr[65:30]);
   assign q3   = qv + (qv <<< 1);

   always_comb begin
      acc_in = acc_ff;
      unique case (cmd.op)
         cbe_pkg::OP_C:   acc_in = qv;
         cbe_pkg::OP_S1:  acc_in = q3;
         cbe_pkg::OP_S2:  acc_in = acc_ff + (q3 <<< 1);
         cbe_pkg::OP_AP1,
         cbe_pkg::OP_BP2,
         cbe_pkg::OP_S3:  acc_in = acc_ff + q3;
         default:         acc_in = acc_ff;
      endcase
   end

   assign resid = acc_ff - AW'(x_ff);
   assign unew  = AW'(u_ff) - AW'(quot);
   assign lo_new = acc_ff < AW'(x_ff) ? t_ff : lo_ff;
   assign hi_new = acc_ff < AW'(x_ff) ? hi_ff : t_ff;
   assign mid_new = (lo_new + hi_new) >>> 1;

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      unique case (cmd.op)
         cbe_pkg::OP_UU: uu_ff <= qv[MW-1:0];
         cbe_pkg::OP_TT: tt_ff <= qv[MW-1:0];
         cbe_pkg::OP_UT,
         cbe_pkg::OP_A:  a_ff  <= qv[MW-1:0];
         cbe_pkg::OP_B:  b_ff  <= qv[MW-1:0];
         default: ;
      endcase
      if (cmd.load) begin
         psat_ff <= psat;
         x_ff    <= $signed(MW'(psat) << SH);
         u_ff    <= $signed(MW'(psat) << SH);
         t_ff    <= $signed(MW'(psat) << SH);
      end
      if (cmd.save_r) begin
         r_ff <= resid;
      end
      if (cmd.upd_u) begin
         if (unew < 0) begin
            u_ff <= '0;
            t_ff <= '0;
         end else if (unew > AW'(cbe_pkg::ONE_Q)) begin
            u_ff <= cbe_pkg::ONE_Q;
            t_ff <= cbe_pkg::ONE_Q;
         end else begin
            u_ff <= unew[MW-1:0];
            t_ff <= unew[MW-1:0];
         end
      end
      if (cmd.bi_init) begin
         lo_ff <= '0;
         hi_ff <= cbe_pkg::ONE_Q;
         t_ff  <= cbe_pkg::ONE_Q >>> 1;
      end
      if (cmd.bi_step) begin
         lo_ff <= lo_new;
         hi_ff <= hi_new;
         u_ff  <= t_ff;
         if (cmd.bi_more) begin
            t_ff <= mid_new;
         end
      end
      if (cmd.out_lin) begin
         eased_ff <= psat_ff;
      end else if (cmd.out_bez) begin
         eased_ff <= yr[cbe_pkg::FIELD_W-1:0];
      end
   end

   always_comb begin
      if (acc_ff < 0) begin
         yc = '0;
      end else if (acc_ff > AW'(cbe_pkg::ONE_Q)) begin
         yc = 31'h4000_0000;
      end else begin
         yc = acc_ff[30:0];
      end
   end
   assign yr = (32'(yc) + HALF) >> SH;

   cbe_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (r_ff),
      .den   (acc_ff),
      .done  (div_done),
      .quot  (quot)
   );

   assign sts.tiny_r   = cbe_pkg::abs_acc(r_ff) < cbe_pkg::TOL_NEWTON;
   assign sts.tiny_d   = cbe_pkg::abs_acc(acc_ff) < cbe_pkg::TOL_NEWTON;
   assign sts.fit_bad  = cbe_pkg::abs_acc(resid) > cbe_pkg::TOL_FIT;
   assign sts.below    = acc_ff < AW'(x_ff);
   assign sts.div_done = div_done;
   assign eased = eased_ff;

endmodule

// ----- rtl/cbe_ctrl.sv -----
// Controller: sequences curve and slope evaluations, Newton steps and bisection.
// Depends on cbe_pkg for the command and status structures and the op tables.
module cbe_ctrl #(
   parameter int NEWTON_STEPS = 5,
   parameter int BISECT_STEPS = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             mode,
   input  cbe_pkg::sts_type sts,
   output logic             busy,
   output logic             rsp_valid,
   output cbe_pkg::cmd_type cmd
);

   localparam int NW = $clog2(NEWTON_STEPS + 1);
   localparam int BW = $clog2(BISECT_STEPS + 1);

   typedef enum logic [13:0] {
      S_IDLE      = 14'h0001,
      S_LOAD      = 14'h0002,
      S_NR_CURVE  = 14'h0004,
      S_NR_SLOPE  = 14'h0008,
      S_NR_CHECK  = 14'h0010,
      S_DIV       = 14'h0020,
      S_UPDATE    = 14'h0040,
      S_FIT       = 14'h0080,
      S_FIT_CHECK = 14'h0100,
      S_BI_EVAL   = 14'h0200,
      S_BI_STEP   = 14'h0400,
      S_FIN       = 14'h0800,
      S_DONE_Y    = 14'h1000,
      S_OUT       = 14'h2000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic [NW-1:0] iter_ff, iter_in;
   logic [BW-1:0] bcnt_ff, bcnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         iter_ff  <= '0;
         bcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         iter_ff  <= iter_in;
         bcnt_ff  <= bcnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      iter_in  = iter_ff;
      bcnt_in  = bcnt_ff;
      cmd      = '0;
      cmd.op   = cbe_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            step_in = '0;
            iter_in = '0;
            if (!mode) begin
               cmd.out_lin = 1'b1;
               state_in = S_OUT;
            end else begin
               state_in = S_NR_CURVE;
            end
         end
         S_NR_CURVE: begin
            cmd.op = cbe_pkg::curve_op(step_ff);
            if (step_ff == cbe_pkg::CURVE_LAST) begin
               step_in  = '0;
               state_in = S_NR_SLOPE;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_NR_SLOPE: begin
            cmd.op = cbe_pkg::slope_op(step_ff);
            cmd.save_r = (step_ff == 3'd0);
            if (step_ff == cbe_pkg::SLOPE_LAST) begin
               step_in  = '0;
               state_in = S_NR_CHECK;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_NR_CHECK: begin
            if (sts.tiny_r || sts.tiny_d) begin
               state_in = S_FIT;
            end else begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.upd_u = 1'b1;
            if (iter_ff == NW'(NEWTON_STEPS - 1)) begin
               state_in = S_FIT;
            end else begin
               iter_in  = iter_ff + NW'(1);
               state_in = S_NR_CURVE;
            end
         end
         S_FIT: begin
            cmd.op = cbe_pkg::curve_op(step_ff);
            if (step_ff == cbe_pkg::CURVE_LAST) begin
               step_in  = '0;
               state_in = S_FIT_CHECK;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_FIT_CHECK: begin
            bcnt_in = '0;
            if (sts.fit_bad) begin
               cmd.bi_init = 1'b1;
               state_in = S_BI_EVAL;
            end else begin
               state_in = S_FIN;
            end
         end
         S_BI_EVAL: begin
            cmd.op = cbe_pkg::curve_op(step_ff);
            if (step_ff == cbe_pkg::CURVE_LAST) begin
               step_in  = '0;
               state_in = S_BI_STEP;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_BI_STEP: begin
            cmd.bi_step = 1'b1;
            if (bcnt_ff == BW'(BISECT_STEPS - 1)) begin
               state_in = S_FIN;
            end else begin
               cmd.bi_more = 1'b1;
               bcnt_in  = bcnt_ff + BW'(1);
               state_in = S_BI_EVAL;
            end
         end
         S_FIN: begin
            cmd.op = cbe_pkg::curve_op(step_ff);
            cmd.sel_y = 1'b1;
            if (step_ff == cbe_pkg::CURVE_LAST) begin
               step_in  = '0;
               state_in = S_DONE_Y;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_DONE_Y: begin
            cmd.out_bez = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

`ifndef SYNTHESIS
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_LOAD))
      else $error("accepted request did not start a computation");
   a_div_started: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> (state_ff == S_DIV))
      else $error("divider started outside the Newton check");
   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> (state_ff == S_DIV))
      else $error("divider finished while not awaited");
`endif

endmodule
